>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. In synthesis the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising edge of the clock while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: property violated");

// Checks that an expression is never true while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> rtl/core/m4vt_pkg.sv
`default_nettype none

package m4vt_pkg;

  localparam int NUM_COMP  = 4;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  // Four full products summed need two guard bits.
  localparam int ACC_W     = PROD_W + 2;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_t;

  typedef struct packed {
    q16_t value;
    logic ovf;
  } row_res_t;

  localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

>>> rtl/core/m4vt_row_sum.sv
`default_nettype none

// Sums the four products of one matrix row exactly, drops the fraction bits
// and saturates the result to the Q16.16 range.
module m4vt_row_sum (
  input  m4vt_pkg::prod_t    prod_i [m4vt_pkg::NUM_COMP],
  output m4vt_pkg::row_res_t res_o
);

  import m4vt_pkg::*;

  acc_t sum;
  acc_t shifted;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      sum = sum + acc_t'(prod_i[i]);
    end
    shifted = sum >>> FRAC_BITS;
  end

  always_comb begin
    if (shifted > acc_t'(Q16_MAX)) begin
      res_o.value = Q16_MAX;
      res_o.ovf   = 1'b1;
    end else if (shifted < acc_t'(Q16_MIN)) begin
      res_o.value = Q16_MIN;
      res_o.ovf   = 1'b1;
    end else begin
      res_o.value = shifted[DATA_W-1:0];
      res_o.ovf   = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mat4_vector_transform_unit.sv
`default_nettype none

// Matrix times vector unit for Q16.16 signed fixed point. The block keeps a
// DIM x DIM matrix (at most 4 x 4), all zero after reset. A load request
// (cmd 0) writes one element at elem_row/elem_col and produces no result;
// indexes at or beyond DIM are ignored. A transform request (cmd 1) carries
// a four-element vector and yields one result: each row's dot product is
// summed exactly, shifted right by 16 (rounding toward minus infinity) and
// saturated to 32 bits, and out_overflow is set when any component
// saturated. Rows at or beyond DIM read as zero. A full matrix product is
// four transforms, one per column of the right-hand matrix. Throughput is one
// request per clock cycle, load or transform in any mix, while the output is
// not stalled. A transform's vector is held in the input register while the
// 32x32 multipliers, one per used matrix element, work on it; its products
// are held in the product register while the row sums and saturation are
// formed for the output register. A load takes effect at its accepting edge,
// so a transform accepted in the very next cycle already sees the new
// element. Each stage holds its contents while the next one is full, so input
// requests keep flowing while a result waits on out_ready, until all three
// stages are occupied.
module mat4_vector_transform_unit #(
  parameter int DIM = 4
) (
  input  wire                    clk,
  input  wire                    rst_n,

  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_cmd,
  input  wire  [1:0]             in_elem_row,
  input  wire  [1:0]             in_elem_col,
  input  wire  m4vt_pkg::q16_t   in_elem_value,
  input  wire  m4vt_pkg::q16_t   in_vec_x,
  input  wire  m4vt_pkg::q16_t   in_vec_y,
  input  wire  m4vt_pkg::q16_t   in_vec_z,
  input  wire  m4vt_pkg::q16_t   in_vec_w,

  output logic                   out_valid,
  input  wire                    out_ready,
  output m4vt_pkg::q16_t         out_x,
  output m4vt_pkg::q16_t         out_y,
  output m4vt_pkg::q16_t         out_z,
  output m4vt_pkg::q16_t         out_w,
  output logic                   out_overflow
);

  import m4vt_pkg::*;

  `include "assert_macros.svh"

  // Only the part of the matrix that meets the four vector components
  // matters; elements outside it are never read.
  localparam int USE = (DIM < NUM_COMP) ? DIM : NUM_COMP;

  // Pipeline occupancy and flow control. A stage can take a new entry when
  // it is empty or when its current entry moves on in the same cycle.
  logic s1_v_r;
  logic s2_v_r;
  logic out_valid_r;
  logic out_free;
  logic s2_free;
  logic s1_free;
  logic in_fire;
  logic load_fire;
  logic xform_fire;

  assign out_free   = !out_valid_r || out_ready;
  assign s2_free    = !s2_v_r || out_free;
  assign s1_free    = !s1_v_r || s2_free;
  assign in_ready   = s1_free;
  assign in_fire    = in_valid && in_ready;
  assign load_fire  = in_fire && (in_cmd == CMD_LOAD);
  assign xform_fire = in_fire && (in_cmd == CMD_XFORM);

  // Matrix storage, indexed [column][row].
  q16_t mat_r [USE][USE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < USE; c++) begin
        for (int r = 0; r < USE; r++) begin
          mat_r[c][r] <= '0;
        end
      end
    end else if (load_fire) begin
      for (int c = 0; c < USE; c++) begin
        for (int r = 0; r < USE; r++) begin
          if (in_elem_col == 2'(c) && in_elem_row == 2'(r)) begin
            mat_r[c][r] <= in_elem_value;
          end
        end
      end
    end
  end

  // Stage 1: input register holding the vector of a transform request.
  q16_t vec_r [NUM_COMP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= xform_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (xform_fire) begin
      vec_r[0] <= in_vec_x;
      vec_r[1] <= in_vec_y;
      vec_r[2] <= in_vec_z;
      vec_r[3] <= in_vec_w;
    end
  end

  // Stage 2: one registered 32x32 product per matrix element, [row][column].
  // Products outside the used part of the matrix are held at zero.
  prod_t prod_nxt [NUM_COMP][NUM_COMP];
  prod_t prod_r   [NUM_COMP][NUM_COMP];

  for (genvar gr = 0; gr < NUM_COMP; gr++) begin : g_prod_row
    for (genvar gc = 0; gc < NUM_COMP; gc++) begin : g_prod_col
      if (gr < USE && gc < USE) begin : g_mul
        assign prod_nxt[gr][gc] = prod_t'(mat_r[gc][gr]) * prod_t'(vec_r[gc]);
      end else begin : g_zero
        assign prod_nxt[gr][gc] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_v_r) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 3: row sums, scaling and saturation into the output register.
  row_res_t row_res [NUM_COMP];
  q16_t     res_r   [NUM_COMP];
  logic     ovf_nxt;
  logic     ovf_r;

  for (genvar gr = 0; gr < NUM_COMP; gr++) begin : g_row
    m4vt_row_sum u_row_sum (
      .prod_i (prod_r[gr]),
      .res_o  (row_res[gr])
    );
  end

  always_comb begin
    ovf_nxt = 1'b0;
    for (int r = 0; r < NUM_COMP; r++) begin
      ovf_nxt = ovf_nxt | row_res[r].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_v_r) begin
      for (int r = 0; r < NUM_COMP; r++) begin
        res_r[r] <= row_res[r].value;
      end
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_x        = res_r[0];
  assign out_y        = res_r[1];
  assign out_z        = res_r[2];
  assign out_w        = res_r[3];
  assign out_overflow = ovf_r;

  // A saturated result must show at least one component at a range limit.
  logic sat_seen;

  always_comb begin
    sat_seen = 1'b0;
    for (int r = 0; r < NUM_COMP; r++) begin
      sat_seen = sat_seen | (res_r[r] == Q16_MAX) | (res_r[r] == Q16_MIN);
    end
  end

  // A load never occupies the input stage; a transform always does.
  `ASSERT_CLK(a_load_no_stage, clk, rst_n, load_fire |=> !s1_v_r)
  `ASSERT_CLK(a_xform_staged, clk, rst_n, xform_fire |=> s1_v_r)
  // A transform held in stage 1 keeps its vector until it moves on.
  `ASSERT_CLK(a_s1_hold, clk, rst_n, s1_v_r && !s2_free |=> $stable(vec_r[0]) && $stable(vec_r[3]))
  `ASSERT_NEVER(a_ovf_sat, clk, rst_n, out_valid_r && ovf_r && !sat_seen)

endmodule

`default_nettype wire
